// File: hdl/ert_pkg.sv
// Shared types, widths and constant tables for the Euler rigid transform.
// No dependencies; imported by the transform top level, its checker and the testbench.
package ert_pkg;

	localparam int COORD_WIDTH     = 32;
	localparam int ANGLE_WIDTH     = 32;
	localparam int TRIG_ITERATIONS = 16;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] point_x;
		logic signed [COORD_WIDTH-1:0] point_y;
		logic signed [COORD_WIDTH-1:0] point_z;
		logic signed [COORD_WIDTH-1:0] offset_x;
		logic signed [COORD_WIDTH-1:0] offset_y;
		logic signed [COORD_WIDTH-1:0] offset_z;
		logic signed [ANGLE_WIDTH-1:0] roll_deg;
		logic signed [ANGLE_WIDTH-1:0] pitch_deg;
		logic signed [ANGLE_WIDTH-1:0] yaw_deg;
	} ert_in_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] world_x;
		logic signed [COORD_WIDTH-1:0] world_y;
		logic signed [COORD_WIDTH-1:0] world_z;
	} ert_out_t;

	// CORDIC arctangent of 2^-i in binary-angle units (2^32 per turn).
	function automatic logic [31:0] atan_turn(input int i);
		logic [31:0] a;
		case (i)
			0:  a = 32'd536870912;
			1:  a = 32'd316933406;
			2:  a = 32'd167458907;
			3:  a = 32'd85004756;
			4:  a = 32'd42667331;
			5:  a = 32'd21354465;
			6:  a = 32'd10679838;
			7:  a = 32'd5340245;
			8:  a = 32'd2670163;
			9:  a = 32'd1335087;
			10: a = 32'd667544;
			11: a = 32'd333772;
			12: a = 32'd166886;
			13: a = 32'd83443;
			14: a = 32'd41722;
			15: a = 32'd20861;
			16: a = 32'd10430;
			17: a = 32'd5215;
			18: a = 32'd2608;
			19: a = 32'd1304;
			20: a = 32'd652;
			21: a = 32'd326;
			22: a = 32'd163;
			23: a = 32'd81;
			default: a = 32'd0;
		endcase
		return a;
	endfunction

	// Rounded binary angle of v/45 of 360 degrees' sub-step: round(v * 2^16 / 360).
	function automatic logic [12:0] frac_turn(input logic [5:0] v);
		logic [12:0] f;
		case (v)
			6'd0:  f = 13'd0;    6'd1:  f = 13'd182;  6'd2:  f = 13'd364;
			6'd3:  f = 13'd546;  6'd4:  f = 13'd728;  6'd5:  f = 13'd910;
			6'd6:  f = 13'd1092; 6'd7:  f = 13'd1274; 6'd8:  f = 13'd1456;
			6'd9:  f = 13'd1638; 6'd10: f = 13'd1820; 6'd11: f = 13'd2002;
			6'd12: f = 13'd2185; 6'd13: f = 13'd2367; 6'd14: f = 13'd2549;
			6'd15: f = 13'd2731; 6'd16: f = 13'd2913; 6'd17: f = 13'd3095;
			6'd18: f = 13'd3277; 6'd19: f = 13'd3459; 6'd20: f = 13'd3641;
			6'd21: f = 13'd3823; 6'd22: f = 13'd4005; 6'd23: f = 13'd4187;
			6'd24: f = 13'd4369; 6'd25: f = 13'd4551; 6'd26: f = 13'd4733;
			6'd27: f = 13'd4915; 6'd28: f = 13'd5097; 6'd29: f = 13'd5279;
			6'd30: f = 13'd5461; 6'd31: f = 13'd5643; 6'd32: f = 13'd5825;
			6'd33: f = 13'd6007; 6'd34: f = 13'd6190; 6'd35: f = 13'd6372;
			6'd36: f = 13'd6554; 6'd37: f = 13'd6736; 6'd38: f = 13'd6918;
			6'd39: f = 13'd7100; 6'd40: f = 13'd7282; 6'd41: f = 13'd7464;
			6'd42: f = 13'd7646; 6'd43: f = 13'd7828; 6'd44: f = 13'd8010;
			default: f = 13'd0;
		endcase
		return f;
	endfunction

endpackage

// File: hdl/euler_rigid_transform.sv
// Z-Y-X Euler rotation plus translation of one camera-frame point per word.
// Throughput is one word per cycle; each stage holds its word until the next frees up.
// The CORDIC chain, one register stage per iteration, sets the depth of the pipeline.
// Reset (arst_n low) clears all valid bits at once; data registers are not reset.
// Depends on ert_pkg.
module euler_rigid_transform (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             src_valid,
	output logic             src_ready,
	input  ert_pkg::ert_in_t src_word,
	output logic             dst_valid,
	input  logic             dst_ready,
	output ert_pkg::ert_out_t dst_word
);
	import ert_pkg::*;

	localparam int IT  = TRIG_ITERATIONS;
	localparam int NS  = IT + 8;          // total register stages
	localparam int XW  = 33;              // Q2.30 sin/cos width with headroom
	localparam int MW  = 34;              // Q2.30 matrix entry width
	localparam int ZW  = 34;              // CORDIC residual angle width
	localparam int PW  = MW + COORD_WIDTH;
	localparam int TW  = PW - 30;
	localparam int SW  = TW + 2;
	localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(652032874);
	localparam logic signed [33:0] FULL_TURN_Q16 = 34'sd23592960;
	localparam logic signed [PW-1:0] PROD_RND = PW'(1) <<< 29;
	localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

	// Stage map: s1 quotient estimate, s2 angle remainder, s3 division by 45,
	// s4 binary angle and quadrant fold, then IT CORDIC stages, s5 first matrix
	// products, s6 matrix entries, s7 entry-by-coordinate products, s8 output.
	localparam int ST_S5 = 4 + IT;
	localparam int ST_S6 = 5 + IT;
	localparam int ST_S7 = 6 + IT;

	function automatic logic signed [XW-1:0] mul30(input logic signed [XW-1:0] a,
			input logic signed [XW-1:0] b);
		logic signed [2*XW-1:0] pr;
		pr = a * b;
		pr = pr + ((2*XW)'(1) <<< 29);
		return XW'(pr >>> 30);
	endfunction

	logic [NS-1:0] vld_s;
	logic [NS-1:0] en;

	// A stage may load when it is empty or when the stage after it loads.
	always_comb begin
		en[NS-1] = !vld_s[NS-1] || dst_ready;
		for (int k = NS - 2; k >= 0; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	assign src_ready = en[0];
	assign dst_valid = vld_s[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) begin
				vld_s[0] <= src_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// The input word rides along until its point and offset are consumed.
	ert_in_t side_s [ST_S7+1];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			side_s[0] <= src_word;
		end
		for (int k = 1; k <= ST_S7; k++) begin
			if (en[k]) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	logic signed [ANGLE_WIDTH-1:0] ang_in [3];
	logic signed [ANGLE_WIDTH-1:0] ang_s1 [3];

	assign ang_in[0] = src_word.roll_deg;
	assign ang_in[1] = src_word.pitch_deg;
	assign ang_in[2] = src_word.yaw_deg;
	assign ang_s1[0] = side_s[0].roll_deg;
	assign ang_s1[1] = side_s[0].pitch_deg;
	assign ang_s1[2] = side_s[0].yaw_deg;

	logic signed [7:0]  qe_s1 [3];
	logic        [24:0] r_s2  [3];
	logic        [24:0] r_s3  [3];
	logic        [18:0] u_s3  [3];

	logic signed [XW-1:0] cor_x_s    [IT+1][3];
	logic signed [XW-1:0] cor_y_s    [IT+1][3];
	logic signed [ZW-1:0] cor_z_s    [IT+1][3];
	logic                 cor_flip_s [IT+1][3];

	// Angle reduction. The whole-degree part, times a reciprocal of 360, gives
	// the turn count to within one; the remainder is then pulled into one turn.
	// Since a full turn is 2^32 binary-angle units, the remainder r is split as
	// 45*u + v, giving u*8192 plus a small table entry for v.
	for (genvar a = 0; a < 3; a++) begin : g_reduce
		logic signed [15:0]  dint;
		logic signed [31:0]  qprod;
		logic signed [33:0]  rr;
		logic        [50:0]  up;
		logic        [24:0]  v_full;
		logic        [31:0]  bam;
		logic        [31:0]  qtr;
		logic        [31:0]  bam_f;

		always_comb begin
			dint  = ang_in[a][ANGLE_WIDTH-1:ANGLE_WIDTH-16];
			qprod = 32'(dint) * 32'sd11651;

			rr = 34'(ang_s1[a]) - 34'(qe_s1[a]) * FULL_TURN_Q16;
			if (rr < 0) begin
				rr = rr + FULL_TURN_Q16;
			end else if (rr >= FULL_TURN_Q16) begin
				rr = rr - FULL_TURN_Q16;
			end

			up = 51'(r_s2[a]) * 51'd47721859;

			v_full = r_s3[a] - 25'(u_s3[a]) * 25'd45;
			bam    = {u_s3[a], 13'd0} + 32'(frac_turn(v_full[5:0]));
			// Angles in the left half-plane are turned by half a turn.
			qtr    = bam + 32'h4000_0000;
			bam_f  = bam ^ {qtr[31], 31'd0};
		end

		always_ff @(posedge clk) begin
			if (en[0]) begin
				qe_s1[a] <= 8'(qprod >>> 22);
			end
			if (en[1]) begin
				r_s2[a] <= rr[24:0];
			end
			if (en[2]) begin
				u_s3[a] <= up[49:31];
				r_s3[a] <= r_s2[a];
			end
			if (en[3]) begin
				cor_x_s[0][a]    <= CORDIC_GAIN;
				cor_y_s[0][a]    <= '0;
				cor_z_s[0][a]    <= ZW'($signed(bam_f));
				cor_flip_s[0][a] <= qtr[31];
			end
		end
	end

	// One CORDIC rotation step per stage for each of the three angles.
	for (genvar i = 0; i < IT; i++) begin : g_cordic
		for (genvar a = 0; a < 3; a++) begin : g_ang
			localparam logic signed [ZW-1:0] ATAN = ZW'(atan_turn(i));
			logic signed [XW-1:0] dx;
			logic signed [XW-1:0] dy;

			assign dx = cor_y_s[i][a] >>> i;
			assign dy = cor_x_s[i][a] >>> i;

			always_ff @(posedge clk) begin
				if (en[4+i]) begin
					if (!cor_z_s[i][a][ZW-1]) begin
						cor_x_s[i+1][a] <= cor_x_s[i][a] - dx;
						cor_y_s[i+1][a] <= cor_y_s[i][a] + dy;
						cor_z_s[i+1][a] <= cor_z_s[i][a] - ATAN;
					end else begin
						cor_x_s[i+1][a] <= cor_x_s[i][a] + dx;
						cor_y_s[i+1][a] <= cor_y_s[i][a] - dy;
						cor_z_s[i+1][a] <= cor_z_s[i][a] + ATAN;
					end
					cor_flip_s[i+1][a] <= cor_flip_s[i][a];
				end
			end
		end
	end

	// Undo the half-turn fold: sin and cos both change sign.
	logic signed [XW-1:0] sn [3];
	logic signed [XW-1:0] cs [3];

	for (genvar a = 0; a < 3; a++) begin : g_unfold
		assign cs[a] = cor_flip_s[IT][a] ? -cor_x_s[IT][a] : cor_x_s[IT][a];
		assign sn[a] = cor_flip_s[IT][a] ? -cor_y_s[IT][a] : cor_y_s[IT][a];
	end

	// Index 0 is roll (x), 1 pitch (y), 2 yaw (z).
	logic signed [XW-1:0] t1_s5, t2_s5, m00_s5, m10_s5, m21_s5, m22_s5;
	logic signed [XW-1:0] szcx_s5, szsx_s5, czcx_s5, czsx_s5;
	logic signed [XW-1:0] sx_s5, cx_s5, sy_s5;

	always_ff @(posedge clk) begin
		if (en[ST_S5]) begin
			t1_s5   <= mul30(cs[2], sn[1]);
			t2_s5   <= mul30(sn[2], sn[1]);
			m00_s5  <= mul30(cs[2], cs[1]);
			m10_s5  <= mul30(sn[2], cs[1]);
			m21_s5  <= mul30(cs[1], sn[0]);
			m22_s5  <= mul30(cs[1], cs[0]);
			szcx_s5 <= mul30(sn[2], cs[0]);
			szsx_s5 <= mul30(sn[2], sn[0]);
			czcx_s5 <= mul30(cs[2], cs[0]);
			czsx_s5 <= mul30(cs[2], sn[0]);
			sx_s5   <= sn[0];
			cx_s5   <= cs[0];
			sy_s5   <= sn[1];
		end
	end

	logic signed [MW-1:0] m_s6 [3][3];

	always_ff @(posedge clk) begin
		if (en[ST_S6]) begin
			m_s6[0][0] <= MW'(m00_s5);
			m_s6[0][1] <= MW'(mul30(t1_s5, sx_s5)) - MW'(szcx_s5);
			m_s6[0][2] <= MW'(mul30(t1_s5, cx_s5)) + MW'(szsx_s5);
			m_s6[1][0] <= MW'(m10_s5);
			m_s6[1][1] <= MW'(mul30(t2_s5, sx_s5)) + MW'(czcx_s5);
			m_s6[1][2] <= MW'(mul30(t2_s5, cx_s5)) - MW'(czsx_s5);
			m_s6[2][0] <= -MW'(sy_s5);
			m_s6[2][1] <= MW'(m21_s5);
			m_s6[2][2] <= MW'(m22_s5);
		end
	end

	logic signed [COORD_WIDTH-1:0] pt_s6 [3];
	logic signed [PW-1:0]          prod_s7 [3][3];

	assign pt_s6[0] = side_s[ST_S6].point_x;
	assign pt_s6[1] = side_s[ST_S6].point_y;
	assign pt_s6[2] = side_s[ST_S6].point_z;

	always_ff @(posedge clk) begin
		if (en[ST_S7]) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s7[i][j] <= PW'(m_s6[i][j]) * PW'(pt_s6[j]);
				end
			end
		end
	end

	// Each term is rounded half up on its own; the sum with the offset is exact
	// and then clamps to the signed coordinate range.
	logic signed [COORD_WIDTH-1:0] off_s7 [3];
	logic signed [COORD_WIDTH-1:0] res    [3];

	assign off_s7[0] = side_s[ST_S7].offset_x;
	assign off_s7[1] = side_s[ST_S7].offset_y;
	assign off_s7[2] = side_s[ST_S7].offset_z;

	always_comb begin
		logic signed [SW-1:0] acc;
		for (int i = 0; i < 3; i++) begin
			acc = SW'(off_s7[i]);
			for (int j = 0; j < 3; j++) begin
				acc = acc + SW'(TW'((prod_s7[i][j] + PROD_RND) >>> 30));
			end
			if (acc > SAT_HI) begin
				res[i] = SAT_HI[COORD_WIDTH-1:0];
			end else if (acc < SAT_LO) begin
				res[i] = SAT_LO[COORD_WIDTH-1:0];
			end else begin
				res[i] = acc[COORD_WIDTH-1:0];
			end
		end
	end

	ert_out_t out_s8;

	always_ff @(posedge clk) begin
		if (en[NS-1]) begin
			out_s8.world_x <= res[0];
			out_s8.world_y <= res[1];
			out_s8.world_z <= res[2];
		end
	end

	assign dst_word = out_s8;

endmodule

// File: hdl/ert_checker.sv
// Port-level checks for the Euler rigid transform, bound to its top level.
// Depends on ert_pkg and euler_rigid_transform.
module ert_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              src_valid,
	input logic              src_ready,
	input ert_pkg::ert_in_t  src_word,
	input logic              dst_valid,
	input logic              dst_ready,
	input ert_pkg::ert_out_t dst_word
);
	import ert_pkg::*;

	// No word may leave while reset holds the pipeline empty.
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !dst_valid)
		else $error("result word shown during reset");

	// An empty output stage always leaves room at the input.
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		!dst_valid |-> src_ready)
		else $error("input stalled with an empty output stage");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_ready |=> dst_valid)
		else $error("result word dropped while stalled");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_ready |=> $stable(dst_word))
		else $error("result word changed while stalled");

endmodule

bind euler_rigid_transform ert_checker u_ert_checker (.*);

// File: tb/sv/euler_rigid_transform_tb.sv
// Testbench for euler_rigid_transform: directed table plus random words, checked against hand-read
// results or a bit-exact predictor of the Z-Y-X rotation and translation. Depends on ert_pkg.
module euler_rigid_transform_tb;
	import ert_pkg::*;

	localparam int  LATENCY     = TRIG_ITERATIONS + 8;
	localparam int  N_RANDOM    = 1800;
	localparam int  CYCLE_LIMIT = 400000;
	localparam longint TURN_Q16 = 64'sd23592960;
	localparam longint GAIN     = 64'sd652032874;

	logic      clk = 1'b0;
	logic      arst_n = 1'b1;
	logic      src_valid = 1'b0;
	logic      src_ready;
	ert_in_t   src_word = '0;
	logic      dst_valid;
	logic      dst_ready = 1'b0;
	ert_out_t  dst_word;

	// Idle modes for sender and receiver, in percent of cycles.
	int        src_idle_pct = 0;
	int        dst_stall_pct = 0;
	int        hold_off = 0;

	ert_out_t  world_q[$];
	int        mismatches = 0;
	int        results_seen = 0;
	longint    cycles = 0;

	euler_rigid_transform i_dut (
		.clk(clk), .arst_n(arst_n),
		.src_valid(src_valid), .src_ready(src_ready), .src_word(src_word),
		.dst_valid(dst_valid), .dst_ready(dst_ready), .dst_word(dst_word)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Arithmetic shift right that floors; SystemVerilog >>> on signed longint does so.
	function automatic longint floor_shift(input longint v, input int s);
		return v >>> s;
	endfunction

	function automatic longint mul_q30(input longint a, input longint b);
		return floor_shift(a * b + (64'sd1 <<< 29), 30);
	endfunction

	// Rounded Q2.30 times a coordinate, split so no intermediate overflows.
	function automatic longint scale_coord(input longint r, input longint p);
		longint ph, pl, a, b, ah, al;
		ph = floor_shift(p, 24);
		pl = p - ph * (64'sd1 <<< 24);
		a  = r * ph;
		b  = r * pl;
		ah = floor_shift(a, 6);
		al = a - ah * 64;
		return ah + floor_shift(al * (64'sd1 <<< 24) + b + (64'sd1 <<< 29), 30);
	endfunction

	// Degrees in Q16.16 to sin and cos in Q2.30 through the CORDIC.
	function automatic void sin_cos_of(input logic signed [31:0] deg, output longint s,
			output longint c);
		longint r, x, y, z, dx, dy;
		logic [63:0] bam;
		bit flip;
		r = longint'(deg) % TURN_Q16;
		if (r < 0) r += TURN_Q16;
		bam = ((64'(r) * 64'd65536 + 64'd180) / 64'd360) & 64'hFFFF_FFFF;
		flip = (((bam + 64'h4000_0000) & 64'hFFFF_FFFF) >= 64'h8000_0000);
		if (flip) bam = (bam + 64'h8000_0000) & 64'hFFFF_FFFF;
		z = longint'(bam);
		if (bam >= 64'h8000_0000) z -= 64'sh1_0000_0000;
		x = GAIN;
		y = 0;
		for (int i = 0; i < TRIG_ITERATIONS && i < 24; i++) begin
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(atan_turn(i));
			end else begin
				x += dx; y -= dy; z += longint'(atan_turn(i));
			end
		end
		if (flip) begin
			x = -x; y = -y;
		end
		c = x;
		s = y;
	endfunction

	function automatic logic signed [COORD_WIDTH-1:0] clamp(input longint v);
		longint hi, lo;
		hi = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) v = hi;
		if (v < lo) v = lo;
		return v[COORD_WIDTH-1:0];
	endfunction

	function automatic ert_out_t transform_point(input ert_in_t w);
		longint p[3], o[3], m[3][3], acc[3];
		longint sx, cx, sy, cy, sz, cz, t;
		ert_out_t res;
		p[0] = w.point_x;  p[1] = w.point_y;  p[2] = w.point_z;
		o[0] = w.offset_x; o[1] = w.offset_y; o[2] = w.offset_z;
		sin_cos_of(w.roll_deg, sx, cx);
		sin_cos_of(w.pitch_deg, sy, cy);
		sin_cos_of(w.yaw_deg, sz, cz);
		t = mul_q30(cz, sy);
		m[0][0] = mul_q30(cz, cy);
		m[0][1] = mul_q30(t, sx) - mul_q30(sz, cx);
		m[0][2] = mul_q30(t, cx) + mul_q30(sz, sx);
		t = mul_q30(sz, sy);
		m[1][0] = mul_q30(sz, cy);
		m[1][1] = mul_q30(t, sx) + mul_q30(cz, cx);
		m[1][2] = mul_q30(t, cx) - mul_q30(cz, sx);
		m[2][0] = -sy;
		m[2][1] = mul_q30(cy, sx);
		m[2][2] = mul_q30(cy, cx);
		for (int i = 0; i < 3; i++)
			acc[i] = scale_coord(m[i][0], p[0]) + scale_coord(m[i][1], p[1])
				+ scale_coord(m[i][2], p[2]) + o[i];
		res.world_x = clamp(acc[0]);
		res.world_y = clamp(acc[1]);
		res.world_z = clamp(acc[2]);
		return res;
	endfunction

	// Directed table. A row with has_exp set carries a result read off by hand.
	typedef struct {
		ert_in_t  word;
		bit       has_exp;
		ert_out_t exp;
	} row_t;

	localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] MINV = 32'sh8000_0000;
	localparam logic signed [31:0] ONE  = 32'sh0001_0000;
	localparam logic signed [31:0] D90  = 32'sd5898240;
	localparam logic signed [31:0] D180 = 32'sd11796480;
	localparam logic signed [31:0] D270 = 32'sd17694720;
	localparam logic signed [31:0] D360 = 32'sd23592960;

	row_t table_rows[$];

	task automatic add_row(input logic signed [31:0] px, py, pz, ox, oy, oz,
			input logic signed [31:0] r, p, y, input bit he,
			input logic signed [31:0] ex, ey, ez);
		row_t rw;
		rw.word = '{px, py, pz, ox, oy, oz, r, p, y};
		rw.has_exp = he;
		rw.exp = '{ex, ey, ez};
		table_rows.push_back(rw);
	endtask

	task automatic build_table();
		// All zero: the result is the offset, zero here.
		add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
		// Zero point, extreme offsets pass straight through.
		add_row(0, 0, 0, MAXV, MINV, ONE, 0, 0, 0, 1, MAXV, MINV, ONE);
		add_row(0, 0, 0, MINV, MAXV, -ONE, D90, D180, D270, 1, MINV, MAXV, -ONE);
		// Large point plus large offset saturates high and low.
		add_row(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, 0, 0, 0, 1, MAXV, MAXV, MAXV);
		add_row(MINV, MINV, MINV, MINV, MINV, MINV, 0, 0, 0, 1, MINV, MINV, MINV);
		// Quadrant boundaries and wrap of each angle.
		add_row(ONE, ONE, ONE, 0, 0, 0, D90, 0, 0, 0, 0, 0, 0);
		add_row(ONE, ONE, ONE, 0, 0, 0, 0, D90, 0, 0, 0, 0, 0);
		add_row(ONE, ONE, ONE, 0, 0, 0, 0, 0, D90, 0, 0, 0, 0);
		add_row(ONE, -ONE, ONE, 0, 0, 0, D180, D180, D180, 0, 0, 0, 0);
		add_row(ONE, ONE, -ONE, 0, 0, 0, D270, D270, D270, 0, 0, 0, 0);
		add_row(ONE, ONE, ONE, 0, 0, 0, D360, -D360, D360, 0, 0, 0, 0);
		add_row(ONE, ONE, ONE, 0, 0, 0, D90 - 1, D270 - 1, -D90, 0, 0, 0, 0);
		// Extreme angle codes, far outside one turn.
		add_row(ONE, 2 * ONE, 3 * ONE, ONE, ONE, ONE, MAXV, MINV, MAXV, 0, 0, 0, 0);
		add_row(MAXV, MINV, MAXV, 0, 0, 0, MINV, MAXV, MINV, 0, 0, 0, 0);
		add_row(MAXV, MAXV, MINV, MAXV, MINV, 0, 32'sd1, -32'sd1, D180 + 1, 0, 0, 0, 0);
		add_row(-1, -1, -1, -1, -1, -1, -1, -1, -1, 0, 0, 0, 0);
		add_row(1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 0, 0);
	endtask

	function automatic logic signed [31:0] random_field();
		case ($urandom_range(0, 7))
			0:       return $urandom_range(0, 1) ? MAXV : MINV;
			1:       return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
			2:       return $signed($urandom_range(0, 2 * 32'd23592960)) - D360;
			default: return $urandom;
		endcase
	endfunction

	function automatic ert_in_t random_word();
		ert_in_t w;
		w.point_x = random_field(); w.point_y = random_field();
		w.point_z = random_field();
		w.offset_x = random_field(); w.offset_y = random_field();
		w.offset_z = random_field();
		w.roll_deg = random_field(); w.pitch_deg = random_field();
		w.yaw_deg = random_field();
		return w;
	endfunction

	// Offer one word, honoring the sender idle rate, and wait for its acceptance.
	// Valid stays high between words that follow without idling.
	// The expected result is queued at the accepting edge.
	task automatic send_word(input ert_in_t w, input bit has_exp, input ert_out_t exp);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			src_valid <= 1'b0;
			@(negedge clk);
		end
		src_word <= w;
		src_valid <= 1'b1;
		do @(posedge clk); while (!src_ready);
		world_q.push_back(has_exp ? exp : transform_point(w));
		@(negedge clk);
	endtask

	task automatic drain();
		src_valid <= 1'b0;
		do @(negedge clk); while (world_q.size() != 0);
	endtask

	task automatic set_phase(input int si, input int ds);
		src_idle_pct = si;
		dst_stall_pct = ds;
	endtask

	// Receiver: random stalls, plus a long hold-off counted here when requested.
	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			dst_ready <= 1'b0;
		end else begin
			dst_ready <= ($urandom_range(0, 99) >= dst_stall_pct);
		end
	end

	// Result checker, sampling at the rising edge.
	always @(posedge clk) begin
		if (arst_n && dst_valid && dst_ready) begin
			results_seen <= results_seen + 1;
			if (world_q.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10)
					$display("unexpected result word %h", dst_word);
			end else begin
				ert_out_t e;
				e = world_q.pop_front();
				if (e !== dst_word) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("mismatch: expected x %0d y %0d z %0d, got x %0d y %0d z %0d",
							e.world_x, e.world_y, e.world_z,
							dst_word.world_x, dst_word.world_y, dst_word.world_z);
				end
			end
		end
	end

	// Watchdog on total cycles.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		ert_out_t none;
		int tail;
		arst_n <= 1'b0;
		none = '0;
		build_table();
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed rows with the pipeline running freely.
		set_phase(0, 0);
		foreach (table_rows[i])
			send_word(table_rows[i].word, table_rows[i].has_exp, table_rows[i].exp);
		drain();

		// Long receiver hold-off while the sender keeps offering words,
		// so the pipeline fills and backs up into the input.
		hold_off = 3 * LATENCY;
		for (int i = 0; i < 2 * LATENCY; i++)
			send_word(random_word(), 1'b0, none);
		// Sender pauses until every outstanding result has arrived.
		drain();

		// Random words across the idle phases.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: set_phase(0, 0);
				1: set_phase(66, 0);
				2: set_phase(0, 66);
				default: set_phase(34, 34);
			endcase
			for (int i = 0; i < N_RANDOM / 4; i++)
				send_word(random_word(), 1'b0, none);
		end

		drain();
		tail = 0;
		while (tail < 2 * LATENCY) begin
			@(negedge clk);
			tail++;
		end
		$display("covered %0d results: directed extremes, angle wraps, saturation,",
			results_seen);
		$display("back-pressure fill and four idle mixes on both channels");
		if (mismatches == 0 && world_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
